// ----- rtl/core/gpa_pkg.sv -----
`default_nettype none

package gpa_pkg;

  // Default sizing of the pool
  localparam int GPA_POOL_SLOTS = 1024;
  localparam int GPA_WORD_BYTES = 8;

  // Fixed field widths of the channels and registers
  localparam int OBJ_W     = 13;
  localparam int POL_W     = 2;
  localparam int CFG_CNT_W = 11;
  localparam int OP_W      = 2;
  localparam int SLOT_IN_W = 10;
  localparam int STAT_W    = 2;
  localparam int OFS_W     = 22;
  localparam int CNT_OUT_W = 11;
  localparam int SLOT_W    = 14;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 64;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // Request opcodes
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_ALLOC   = 2'd0;
  localparam op_t OP_RELEASE = 2'd1;
  localparam op_t OP_INIT    = 2'd2;

  // Result status codes
  typedef logic [STAT_W-1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOMEM   = 2'd1;
  localparam status_t ST_BADCFG  = 2'd2;
  localparam status_t ST_ALLFREE = 2'd3;

  // Growth policies
  typedef logic [POL_W-1:0] policy_t;
  localparam policy_t POL_FIXED     = 2'd0;
  localparam policy_t POL_LIMITED   = 2'd1;
  localparam policy_t POL_UNLIMITED = 2'd2;

  // Register indexes
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_OBJECT_BYTES    = 3'd0;
  localparam reg_idx_t REG_GROWTH_POLICY   = 3'd1;
  localparam reg_idx_t REG_INITIAL_SLOTS   = 3'd2;
  localparam reg_idx_t REG_EXTENSION_SLOTS = 3'd3;
  localparam reg_idx_t REG_SLOT_CAP        = 3'd4;

  // Configuration as seen by the pool controller
  typedef struct packed {
    logic [OBJ_W-1:0]     object_bytes;
    policy_t              growth_policy;
    logic [CFG_CNT_W-1:0] initial_slots;
    logic [CFG_CNT_W-1:0] extension_slots;
    logic [CFG_CNT_W-1:0] slot_cap;
    logic [SLOT_W-1:0]    slot_bytes;
  } cfg_t;

  // One result of the pool controller
  typedef struct packed {
    logic                 grew;
    logic [CNT_OUT_W-1:0] total_slots;
    logic [CNT_OUT_W-1:0] free_slots;
    logic [OFS_W-1:0]     slot_offset;
    logic [SLOT_IN_W-1:0] granted_slot;
    status_t              status;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/gpa_ram.sv -----
`default_nettype none

module gpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/gpa_cfg.sv -----
`default_nettype none

module gpa_cfg import gpa_pkg::*; #(
  parameter int WORD_BYTES = GPA_WORD_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic      [APB_DATA_W-1:0] cfg_prdata,
  output cfg_t                       cfg
);

  // Reciprocal for rounding up to whole words
  localparam int RND_K = 16;
  localparam int RND_R = ((1 << RND_K) + WORD_BYTES - 1) / WORD_BYTES;
  localparam int RND_R_W = RND_K + 1;
  localparam logic [SLOT_W-1:0] WB_S = SLOT_W'(WORD_BYTES);
  localparam logic [SLOT_W-1:0] WB_M1 = SLOT_W'(WORD_BYTES - 1);

  logic [OBJ_W-1:0]     object_bytes_r;
  policy_t              growth_policy_r;
  logic [CFG_CNT_W-1:0] initial_slots_r;
  logic [CFG_CNT_W-1:0] extension_slots_r;
  logic [CFG_CNT_W-1:0] slot_cap_r;
  logic [SLOT_W-1:0]    quot_r;
  logic [SLOT_W-1:0]    quot_nxt;

  logic                         wr_en;
  reg_idx_t                     wr_idx;
  logic [SLOT_W-1:0]            obj_max;
  logic [SLOT_W-1:0]            rnd_x;
  logic [SLOT_W+RND_R_W-1:0]    rnd_prod;
  logic [SLOT_W:0]              rnd_cand;

  assign wr_en  = cfg_psel & cfg_penable & cfg_pwrite;
  assign wr_idx = cfg_paddr[APB_ADDR_W-1:2];

  // Hold the registers, update on a completed write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      object_bytes_r    <= OBJ_W'(8);
      growth_policy_r   <= POL_FIXED;
      initial_slots_r   <= CFG_CNT_W'(64);
      extension_slots_r <= CFG_CNT_W'(64);
      slot_cap_r        <= CFG_CNT_W'(1024);
    end else if (wr_en) begin
      case (wr_idx)
        REG_OBJECT_BYTES:    object_bytes_r    <= cfg_pwdata[OBJ_W-1:0];
        REG_GROWTH_POLICY:   growth_policy_r   <= cfg_pwdata[POL_W-1:0];
        REG_INITIAL_SLOTS:   initial_slots_r   <= cfg_pwdata[CFG_CNT_W-1:0];
        REG_EXTENSION_SLOTS: extension_slots_r <= cfg_pwdata[CFG_CNT_W-1:0];
        REG_SLOT_CAP:        slot_cap_r        <= cfg_pwdata[CFG_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Round the object size up to whole words: estimate the quotient by reciprocal
  always_comb begin
    obj_max  = (SLOT_W'(object_bytes_r) < WB_S) ? WB_S : SLOT_W'(object_bytes_r);
    rnd_x    = obj_max + WB_M1;
    rnd_prod = (SLOT_W+RND_R_W)'(rnd_x) * (SLOT_W+RND_R_W)'(RND_R);
    quot_nxt = rnd_prod[RND_K +: SLOT_W];
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
  end

  // Correct an estimate that came out one word too high
  always_comb begin
    rnd_cand = (SLOT_W+1)'(quot_r) * (SLOT_W+1)'(WB_S);
    if (rnd_cand > (SLOT_W+1)'(rnd_x)) begin
      rnd_cand = rnd_cand - (SLOT_W+1)'(WB_S);
    end
  end

  always_comb begin
    cfg.object_bytes    = object_bytes_r;
    cfg.growth_policy   = growth_policy_r;
    cfg.initial_slots   = initial_slots_r;
    cfg.extension_slots = extension_slots_r;
    cfg.slot_cap        = slot_cap_r;
    cfg.slot_bytes      = rnd_cand[SLOT_W-1:0];
  end

  // Read back the addressed register
  always_comb begin
    case (wr_idx)
      REG_OBJECT_BYTES:    cfg_prdata = APB_DATA_W'(object_bytes_r);
      REG_GROWTH_POLICY:   cfg_prdata = APB_DATA_W'(growth_policy_r);
      REG_INITIAL_SLOTS:   cfg_prdata = APB_DATA_W'(initial_slots_r);
      REG_EXTENSION_SLOTS: cfg_prdata = APB_DATA_W'(extension_slots_r);
      REG_SLOT_CAP:        cfg_prdata = APB_DATA_W'(slot_cap_r);
      default:             cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/gpa_core.sv -----
`default_nettype none

module gpa_core import gpa_pkg::*; #(
  parameter int POOL_SLOTS = GPA_POOL_SLOTS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire op_t                  in_op,
  input  wire logic [SLOT_IN_W-1:0] in_slot,
  input  wire cfg_t                 cfg,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output res_t                      res
);

  localparam int IDX_W = $clog2(POOL_SLOTS);
  localparam int CNT_W = $clog2(POOL_SLOTS + 1);
  localparam int CW    = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;
  localparam int SUM_W = CW + 1;
  localparam int MUL_W = IDX_W + SLOT_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FILL = 5'b00010,
    S_RD   = 5'b00100,
    S_POP  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     free_r, free_nxt;
  logic [CNT_W-1:0]     created_r, created_nxt;
  policy_t              pol_r, pol_nxt;
  logic [CFG_CNT_W-1:0] ext_r, ext_nxt;
  logic [CFG_CNT_W-1:0] cap_r, cap_nxt;
  logic [SLOT_W-1:0]    slot_bytes_r, slot_bytes_nxt;
  logic [IDX_W-1:0]     fill_addr_r, fill_addr_nxt;
  logic [CNT_W-1:0]     fill_left_r, fill_left_nxt;
  logic                 fill_init_r, fill_init_nxt;
  status_t              status_r, status_nxt;
  logic [IDX_W-1:0]     granted_r, granted_nxt;
  logic [OFS_W-1:0]     offset_r, offset_nxt;
  logic                 grew_r, grew_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_rdata;

  logic             fin;
  logic [SUM_W-1:0] grow_sum;
  logic             grow_ok;
  logic [MUL_W-1:0] offset_prod;

  // Link memory: entry s holds the slot after s on the free list
  gpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (POOL_SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (head_r),
    .rdata (mem_rdata)
  );

  // Decide whether an empty pool may grow by one extension
  always_comb begin
    grow_sum = SUM_W'(created_r) + SUM_W'(ext_r);
    case (pol_r)
      POL_LIMITED:   grow_ok = (grow_sum <= SUM_W'(cap_r)) && (ext_r != '0);
      POL_UNLIMITED: grow_ok = (ext_r != '0);
      default:       grow_ok = 1'b0;
    endcase
    if (grow_sum > SUM_W'(POOL_SLOTS)) begin
      grow_ok = 1'b0;
    end
  end

  assign offset_prod = MUL_W'(head_r) * MUL_W'(slot_bytes_r);
  assign in_ready    = (state_r == S_IDLE);

  // Sequence requests through the link memory
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    free_nxt       = free_r;
    created_nxt    = created_r;
    pol_nxt        = pol_r;
    ext_nxt        = ext_r;
    cap_nxt        = cap_r;
    slot_bytes_nxt = slot_bytes_r;
    fill_addr_nxt  = fill_addr_r;
    fill_left_nxt  = fill_left_r;
    fill_init_nxt  = fill_init_r;
    status_nxt     = status_r;
    granted_nxt    = granted_r;
    offset_nxt     = offset_r;
    grew_nxt       = grew_r;
    mem_we         = 1'b0;
    mem_waddr      = fill_addr_r;
    mem_wdata      = '0;
    fin            = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt  = ST_OK;
          granted_nxt = '0;
          offset_nxt  = '0;
          grew_nxt    = 1'b0;
          case (in_op)
            OP_INIT: begin
              head_nxt    = '0;
              free_nxt    = '0;
              created_nxt = '0;
              if (cfg.object_bytes == '0 || cfg.initial_slots == '0) begin
                status_nxt = ST_BADCFG;
                fin        = 1'b1;
              end else if (CW'(cfg.initial_slots) > CW'(POOL_SLOTS)) begin
                status_nxt = ST_NOMEM;
                fin        = 1'b1;
              end else begin
                pol_nxt       = cfg.growth_policy;
                ext_nxt       = cfg.extension_slots;
                cap_nxt       = cfg.slot_cap;
                free_nxt      = CNT_W'(cfg.initial_slots);
                created_nxt   = CNT_W'(cfg.initial_slots);
                fill_addr_nxt = '0;
                fill_left_nxt = CNT_W'(cfg.initial_slots);
                fill_init_nxt = 1'b1;
                state_nxt     = S_FILL;
              end
            end
            OP_ALLOC: begin
              if (created_r == '0) begin
                status_nxt = ST_BADCFG;
                fin        = 1'b1;
              end else if (free_r == '0) begin
                if (grow_ok) begin
                  head_nxt      = IDX_W'(created_r);
                  created_nxt   = created_r + CNT_W'(ext_r);
                  free_nxt      = CNT_W'(ext_r);
                  fill_addr_nxt = IDX_W'(created_r);
                  fill_left_nxt = CNT_W'(ext_r);
                  fill_init_nxt = 1'b0;
                  grew_nxt      = 1'b1;
                  state_nxt     = S_FILL;
                end else begin
                  status_nxt = ST_NOMEM;
                  fin        = 1'b1;
                end
              end else begin
                // link of the head was read at this edge
                state_nxt = S_POP;
              end
            end
            OP_RELEASE: begin
              if (free_r >= created_r) begin
                status_nxt = ST_ALLFREE;
              end else if (CW'(in_slot) < CW'(created_r) &&
                           CW'(in_slot) < CW'(POOL_SLOTS)) begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(in_slot);
                mem_wdata = head_r;
                head_nxt  = IDX_W'(in_slot);
                free_nxt  = free_r + CNT_W'(1);
              end
              fin = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // Link fresh slots in ascending order, last one ends the list
      S_FILL: begin
        mem_we        = 1'b1;
        mem_waddr     = fill_addr_r;
        mem_wdata     = (fill_left_r == CNT_W'(1)) ? '0 : fill_addr_r + IDX_W'(1);
        fill_addr_nxt = fill_addr_r + IDX_W'(1);
        fill_left_nxt = fill_left_r - CNT_W'(1);
        if (fill_init_r) begin
          slot_bytes_nxt = cfg.slot_bytes;
        end
        if (fill_left_r == CNT_W'(1)) begin
          if (fill_init_r) begin
            fin = 1'b1;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      // Fetch the link of the new head
      S_RD: begin
        state_nxt = S_POP;
      end

      // Pop the head
      S_POP: begin
        granted_nxt = head_r;
        offset_nxt  = offset_prod[OFS_W-1:0];
        head_nxt    = mem_rdata;
        free_nxt    = free_r - CNT_W'(1);
        fin         = 1'b1;
      end

      // Hold the result until the output register frees up
      S_DONE: begin
        fin = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = res_ready ? S_IDLE : S_DONE;
    end
  end

  // Present the result of the finishing step
  always_comb begin
    res_valid        = fin;
    res.status       = status_nxt;
    res.granted_slot = SLOT_IN_W'(granted_nxt);
    res.slot_offset  = offset_nxt;
    res.free_slots   = CNT_OUT_W'(free_nxt);
    res.total_slots  = CNT_OUT_W'(created_nxt);
    res.grew         = grew_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      free_r      <= '0;
      created_r   <= '0;
      fill_init_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      created_r   <= created_nxt;
      fill_init_r <= fill_init_nxt;
    end
  end

  // Latched pool settings and result payload
  always_ff @(posedge clk) begin
    pol_r        <= pol_nxt;
    ext_r        <= ext_nxt;
    cap_r        <= cap_nxt;
    slot_bytes_r <= slot_bytes_nxt;
    fill_addr_r  <= fill_addr_nxt;
    fill_left_r  <= fill_left_nxt;
    status_r     <= status_nxt;
    granted_r    <= granted_nxt;
    offset_r     <= offset_nxt;
    grew_r       <= grew_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/growable_object_pool_allocator.sv -----
// Slot pool allocator with a last-in first-out free list held in a link memory.
// in_*  : requests. in_tuser carries the opcode (allocate, release, initialize),
//         in_tdata the slot index for a release.
// out_* : one result per request: status, granted slot, byte offset, free and
//         total slot counts, and a flag for an allocate that grew the pool.
// cfg_* : register port; values take effect at the next initialize.
// States from request accept to result in the output register:
//   release, failed or unused request : S_IDLE, a request every cycle unless stalled
//   allocate from a non-empty pool    : S_POP, using the link memory read of the head
//   initialize                        : S_FILL, one link write per initial slot
//   allocate that grows the pool      : S_FILL for the new slots, then S_RD and S_POP
// The link memory is written one slot per cycle while slots are created.
// Reset empties the pool and loads the register defaults; the link memory is
// not cleared, initialize writes every link it later reads.
// A request is taken while an earlier result waits in the output register; a
// finished result waits inside the block until that register frees up, and
// no further request is taken meanwhile.
`default_nettype none

module growable_object_pool_allocator import gpa_pkg::*; #(
  parameter int POOL_SLOTS = GPA_POOL_SLOTS,
  parameter int WORD_BYTES = GPA_WORD_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] slot_index
  input  wire logic [OP_W-1:0]       in_tuser,   // [1:0] opcode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [1:0] status, [11:2] granted_slot, [33:12] slot_offset, [44:34] free_slots,
  // [55:45] total_slots, [56] grew
  output logic      [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic      [APB_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int RES_W = $bits(res_t);

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic res_ready;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign cfg_pready = 1'b1;

  gpa_cfg #(
    .WORD_BYTES (WORD_BYTES)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg         (cfg)
  );

  gpa_core #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_slot   (in_tdata[SLOT_IN_W-1:0]),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load a result when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= OUT_DATA_W'(RES_W'(res));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ----- tb/growable_object_pool_allocator_test.sv -----
`timescale 1ns / 1ps

module growable_object_pool_allocator_test;
  import gpa_pkg::*;

  localparam int SLOTS = GPA_POOL_SLOTS;
  localparam int WORD = GPA_WORD_BYTES;
  localparam int RES_W = $bits(res_t);
  localparam int TARGET_REQUESTS = 1850;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PRINT_LIMIT = 40;

  // Codes the package leaves unnamed
  localparam op_t OP_UNUSED = 2'd3;
  localparam policy_t POL_UNDEF = 2'd3;

  typedef enum logic [0:0] {ROW_WRITE, ROW_REQ} row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    reg_idx_t       target;
    logic [12:0]    value;
    op_t            op;
    logic [9:0]     slot;
    logic           typed;
    status_t        want_status;
    logic [10:0]    want_free;
    logic [10:0]    want_total;
  } plan_row_t;

  // Directed opening: error paths, extremes, growth rules
  localparam int PLAN_LEN = 39;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_ALLOC,   10'd0,    1'b1, ST_BADCFG,  11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_RELEASE, 10'd5,    1'b1, ST_ALLFREE, 11'd0, 11'd0},
    '{ROW_WRITE, REG_OBJECT_BYTES,    13'd0,    OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_INIT,    10'd0,    1'b1, ST_BADCFG,  11'd0, 11'd0},
    '{ROW_WRITE, REG_OBJECT_BYTES,    13'd4096, OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_WRITE, REG_INITIAL_SLOTS,   13'd0,    OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_INIT,    10'd0,    1'b1, ST_BADCFG,  11'd0, 11'd0},
    '{ROW_WRITE, REG_INITIAL_SLOTS,   13'd2047, OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_INIT,    10'd0,    1'b1, ST_NOMEM,   11'd0, 11'd0},
    '{ROW_WRITE, REG_INITIAL_SLOTS,   13'd1024, OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_INIT,    10'd0,    1'b1, ST_OK,   11'd1024,
      11'd1024},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_ALLOC,   10'd1023, 1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_RELEASE, 10'd1023, 1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_UNUSED,  10'd1023, 1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_WRITE, REG_GROWTH_POLICY,   13'(POL_UNDEF), OP_ALLOC, 10'd0, 1'b0, ST_OK,     11'd0, 11'd0},
    '{ROW_WRITE, REG_INITIAL_SLOTS,   13'd1,    OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_WRITE, REG_OBJECT_BYTES,    13'd1,    OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_INIT,    10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_ALLOC,   10'd0,    1'b1, ST_NOMEM,   11'd0, 11'd1},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_RELEASE, 10'd1023, 1'b1, ST_OK,      11'd0, 11'd1},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_RELEASE, 10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_RELEASE, 10'd0,    1'b1, ST_ALLFREE, 11'd1, 11'd1},
    '{ROW_WRITE, REG_GROWTH_POLICY,   13'(POL_LIMITED), OP_ALLOC, 10'd0, 1'b0, ST_OK,   11'd0, 11'd0},
    '{ROW_WRITE, REG_EXTENSION_SLOTS, 13'd2,    OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_WRITE, REG_SLOT_CAP,        13'd3,    OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_WRITE, REG_OBJECT_BYTES,    13'd13,   OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_INIT,    10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_ALLOC,   10'd0,    1'b1, ST_NOMEM,   11'd0, 11'd3},
    '{ROW_WRITE, REG_GROWTH_POLICY,   13'(POL_UNLIMITED), OP_ALLOC, 10'd0, 1'b0, ST_OK, 11'd0, 11'd0},
    '{ROW_WRITE, REG_EXTENSION_SLOTS, 13'd1024, OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_INIT,    10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_ALLOC,   10'd0,    1'b0, ST_OK,      11'd0, 11'd0},
    '{ROW_REQ,   REG_OBJECT_BYTES,    13'd0,    OP_ALLOC,   10'd0,    1'b1, ST_NOMEM,   11'd0, 11'd1}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [9:0] slot_index
  logic [OP_W-1:0]       in_tuser;   // [1:0] opcode
  logic                  out_tvalid;
  logic                  out_tready;
  // [1:0] status, [11:2] granted_slot, [33:12] slot_offset, [44:34] free_slots,
  // [55:45] total_slots, [56] grew
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  growable_object_pool_allocator u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Pool shadow: free list links, head and counts
  logic [SLOT_IN_W-1:0] link_mem [SLOTS];
  logic [10:0]          free_head;
  logic [10:0]          free_cnt;
  logic [10:0]          made_cnt;
  logic [10:0]          fresh_idx;

  // Register shadow and the setup latched by the last good initialize
  logic [OBJ_W-1:0]     reg_obj;
  policy_t              reg_pol;
  logic [10:0]          reg_init;
  logic [10:0]          reg_ext;
  logic [10:0]          reg_cap;
  int                   pool_bytes;
  policy_t              pool_pol;
  logic [10:0]          pool_ext;
  logic [10:0]          pool_cap;

  res_t due_results [$];
  int   held_slots [$];
  bit   steady_send;
  int   err_count;
  int   results_seen;
  int   n_requests;
  int   n_grants;
  int   n_growths;
  int   n_refused;
  int   n_setups;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("growable_object_pool_allocator_test: done, errors");
    $finish;
  end

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    err_count++;
    if (err_count <= PRINT_LIMIT) begin
      $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    end
  endtask

  // Append n fresh slots at the head in ascending order
  function automatic void create_slots(logic [10:0] n);
    int i;
    int s;
    int first;
    logic [10:0] nxt;
    first = fresh_idx;
    for (i = 0; i < n; i++) begin
      s = first + i;
      if (i + 1 < n) begin
        nxt = 11'(s + 1);
      end else begin
        nxt = (free_cnt != 0) ? free_head : 11'd0;
      end
      if (s < SLOTS) link_mem[s] = nxt[SLOT_IN_W-1:0];
    end
    free_head = 11'(first);
    fresh_idx = 11'(first + int'(n));
    made_cnt  = made_cnt + n;
    free_cnt  = free_cnt + n;
  endfunction

  // Work out one request's result and advance the pool shadow
  function automatic res_t apply_to_pool(op_t op, logic [SLOT_IN_W-1:0] idx);
    res_t r;
    bit   allow;
    int   grown;
    int   b;
    r = '0;
    case (op)
      OP_INIT: begin
        free_head = '0;
        free_cnt  = '0;
        made_cnt  = '0;
        fresh_idx = '0;
        if (reg_obj == 0 || reg_init == 0) begin
          r.status = ST_BADCFG;
        end else if (int'(reg_init) > SLOTS) begin
          r.status = ST_NOMEM;
        end else begin
          b = (int'(reg_obj) < WORD) ? WORD : int'(reg_obj);
          pool_bytes = (b + WORD - 1) / WORD * WORD;
          pool_pol = reg_pol;
          pool_ext = reg_ext;
          pool_cap = reg_cap;
          create_slots(reg_init);
        end
      end
      OP_ALLOC: begin
        if (made_cnt == 0) begin
          r.status = ST_BADCFG;
        end else begin
          if (free_cnt == 0) begin
            grown = int'(made_cnt) + int'(pool_ext);
            case (pool_pol)
              POL_LIMITED:   allow = (grown <= int'(pool_cap)) && pool_ext != 0;
              POL_UNLIMITED: allow = pool_ext != 0;
              default:       allow = 1'b0;
            endcase
            if (allow && grown > SLOTS) allow = 1'b0;
            if (allow) begin
              create_slots(pool_ext);
              r.grew = 1'b1;
            end else begin
              r.status = ST_NOMEM;
            end
          end
          if (r.status == ST_OK && free_cnt != 0) begin
            r.granted_slot = free_head[SLOT_IN_W-1:0];
            r.slot_offset  = OFS_W'(int'(free_head) * pool_bytes);
            free_head = 11'(link_mem[free_head[SLOT_IN_W-1:0]]);
            free_cnt  = free_cnt - 11'd1;
          end
        end
      end
      OP_RELEASE: begin
        if (free_cnt >= made_cnt) begin
          r.status = ST_ALLFREE;
        end else if (11'(idx) < made_cnt) begin
          link_mem[idx] = free_head[SLOT_IN_W-1:0];
          free_head = 11'(idx);
          free_cnt  = free_cnt + 11'd1;
        end
      end
      default: ;
    endcase
    r.free_slots  = free_cnt;
    r.total_slots = made_cnt;
    return r;
  endfunction

  // Write one register through the setup and access phases
  task automatic write_reg(reg_idx_t sel, int unsigned value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= APB_ADDR_W'(4 * sel);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (sel)
      REG_OBJECT_BYTES:    reg_obj  = value[OBJ_W-1:0];
      REG_GROWTH_POLICY:   reg_pol  = value[POL_W-1:0];
      REG_INITIAL_SLOTS:   reg_init = value[10:0];
      REG_EXTENSION_SLOTS: reg_ext  = value[10:0];
      REG_SLOT_CAP:        reg_cap  = value[10:0];
      default: ;
    endcase
  endtask

  // Send one request and queue what it should return
  task automatic issue_request(op_t op, logic [SLOT_IN_W-1:0] idx, bit typed = 1'b0,
                               status_t st = ST_OK, logic [10:0] nfree = '0,
                               logic [10:0] ntotal = '0);
    res_t predicted;
    res_t stated;
    int   gap;
    int   r;
    r = $urandom_range(0, 19);
    if (steady_send || r < 11) gap = 0;
    else if (r < 18) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'(idx);
    do @(posedge clk); while (!in_tready);
    predicted = apply_to_pool(op, idx);
    if (typed) begin
      stated = '0;
      stated.status      = st;
      stated.free_slots  = nfree;
      stated.total_slots = ntotal;
      due_results.push_back(stated);
    end else begin
      due_results.push_back(predicted);
    end
    n_requests++;
    if (op == OP_INIT) held_slots.delete();
    if (op == OP_ALLOC && predicted.status == ST_OK) begin
      held_slots.push_back(int'(predicted.granted_slot));
      n_grants++;
    end
    if (predicted.grew) n_growths++;
    if (op == OP_ALLOC && predicted.status == ST_NOMEM) n_refused++;
  endtask

  // Drop valid and wait for every queued result
  task automatic settle_block();
    int waited;
    in_tvalid <= 1'b0;
    waited = 0;
    while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (due_results.size() != 0) begin
      flag_mismatch("results never returned", due_results.size(), 0);
      due_results.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  // One random setup: program registers, initialize, then mostly valid traffic
  task automatic run_setup();
    int r;
    int len;
    int alloc_pct;
    int pick;
    int unsigned val;
    settle_block();

    r = $urandom_range(0, 19);
    case (r)
      0:       val = 0;
      1:       val = 4096;
      2:       val = 4095;
      3, 4:    val = $urandom_range(1, 8);
      5, 6:    val = $urandom_range(1, 4096);
      default: val = $urandom_range(9, 200);
    endcase
    write_reg(REG_OBJECT_BYTES, val);

    r = $urandom_range(0, 15);
    if (r == 0) val = POL_UNDEF;
    else if (r < 5) val = POL_FIXED;
    else if (r < 11) val = POL_LIMITED;
    else val = POL_UNLIMITED;
    write_reg(REG_GROWTH_POLICY, val);

    r = $urandom_range(0, 39);
    case (r)
      0:       val = 0;
      1:       val = $urandom_range(1025, 2047);
      2:       val = 1024;
      3:       val = $urandom_range(200, 1024);
      default: val = $urandom_range(1, 24);
    endcase
    write_reg(REG_INITIAL_SLOTS, val);

    r = $urandom_range(0, 19);
    case (r)
      0:       val = 0;
      1:       val = 1024;
      2:       val = $urandom_range(1025, 2047);
      3:       val = $urandom_range(64, 512);
      default: val = $urandom_range(1, 12);
    endcase
    write_reg(REG_EXTENSION_SLOTS, val);

    r = $urandom_range(0, 9);
    case (r)
      0:       val = 0;
      1:       val = 1024;
      2:       val = 2047;
      default: val = int'(reg_init) + $urandom_range(0, 48);
    endcase
    if (val > 2047) val = 2047;
    write_reg(REG_SLOT_CAP, val);

    steady_send = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 2);
    alloc_pct = (r == 0) ? 35 : (r == 1) ? 55 : 75;
    n_setups++;
    issue_request(OP_INIT, SLOT_IN_W'($urandom_range(0, 1023)));

    len = $urandom_range(30, 90);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
        issue_request(OP_ALLOC, SLOT_IN_W'($urandom_range(0, 1023)));
      end else if (r < 88) begin
        if (held_slots.size() != 0) begin
          pick = $urandom_range(0, held_slots.size() - 1);
          val = held_slots[pick];
          held_slots.delete(pick);
          issue_request(OP_RELEASE, SLOT_IN_W'(val));
        end else begin
          issue_request(OP_ALLOC, SLOT_IN_W'($urandom_range(0, 1023)));
        end
      end else if (r < 93) begin
        issue_request(OP_RELEASE, SLOT_IN_W'($urandom_range(0, 1023)));
      end else if (r < 97) begin
        issue_request(OP_UNUSED, SLOT_IN_W'($urandom_range(0, 1023)));
      end else if (r < 99) begin
        // any created slot, so a slot already free may go back twice
        val = (made_cnt != 0) ? $urandom_range(0, int'(made_cnt) - 1) : $urandom_range(0, 1023);
        issue_request(OP_RELEASE, SLOT_IN_W'(val));
      end else begin
        issue_request(OP_INIT, SLOT_IN_W'($urandom_range(0, 1023)));
      end
    end
  endtask

  // Result side: random stalls, short mostly, some long, some stretches with none
  initial begin
    int hold_cnt;
    int mode;
    out_tready = 1'b0;
    hold_cnt = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_cnt == 0) begin
        mode = $urandom_range(0, 19);
        if (mode < 6) hold_cnt = $urandom_range(5, 60);
        else if (mode < 18) hold_cnt = $urandom_range(5, 40);
        else hold_cnt = $urandom_range(10, 50);
      end
      hold_cnt--;
      if (mode < 6) out_tready <= 1'b1;
      else if (mode < 18) out_tready <= ($urandom_range(0, 3) != 0);
      else out_tready <= 1'b0;
    end
  end

  // Compare each returned result with the oldest expectation
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[RES_W-1:0]);
      if (out_tdata[OUT_DATA_W-1:RES_W] !== '0) begin
        flag_mismatch("pad bits", int'(out_tdata[OUT_DATA_W-1:RES_W]), 0);
      end
      if (due_results.size() == 0) begin
        flag_mismatch("result with nothing pending, status", got.status, 0);
      end else begin
        want = due_results.pop_front();
        if (got.status !== want.status) flag_mismatch("status", got.status, want.status);
        if (got.granted_slot !== want.granted_slot) begin
          flag_mismatch("granted_slot", got.granted_slot, want.granted_slot);
        end
        if (got.slot_offset !== want.slot_offset) begin
          flag_mismatch("slot_offset", got.slot_offset, want.slot_offset);
        end
        if (got.free_slots !== want.free_slots) begin
          flag_mismatch("free_slots", got.free_slots, want.free_slots);
        end
        if (got.total_slots !== want.total_slots) begin
          flag_mismatch("total_slots", got.total_slots, want.total_slots);
        end
        if (got.grew !== want.grew) flag_mismatch("grew", got.grew, want.grew);
      end
      results_seen++;
    end
  end

  initial begin
    int i;
    int k;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_ALLOC;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    steady_send = 1'b0;
    err_count   = 0;
    results_seen = 0;
    n_requests  = 0;
    n_grants    = 0;
    n_growths   = 0;
    n_refused   = 0;
    n_setups    = 0;

    // Shadow state as it stands after reset
    for (i = 0; i < SLOTS; i++) link_mem[i] = '0;
    free_head  = '0;
    free_cnt   = '0;
    made_cnt   = '0;
    fresh_idx  = '0;
    reg_obj    = 13'd8;
    reg_pol    = POL_FIXED;
    reg_init   = 11'd64;
    reg_ext    = 11'd64;
    reg_cap    = 11'd1024;
    pool_bytes = WORD;
    pool_pol   = POL_FIXED;
    pool_ext   = 11'd64;
    pool_cap   = 11'd1024;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (k = 0; k < PLAN_LEN; k++) begin
      if (PLAN[k].kind == ROW_WRITE) begin
        settle_block();
        write_reg(PLAN[k].target, PLAN[k].value);
      end else begin
        issue_request(PLAN[k].op, PLAN[k].slot, PLAN[k].typed, PLAN[k].want_status,
                      PLAN[k].want_free, PLAN[k].want_total);
      end
    end

    // Random setups until enough requests went through
    while (n_requests < TARGET_REQUESTS) run_setup();

    settle_block();
    repeat (20) @(posedge clk);
    if (due_results.size() != 0) flag_mismatch("results left over", due_results.size(), 0);

    $display("covered %0d requests over %0d random pool setups plus the directed table",
             n_requests, n_setups);
    $display("%0d grants, %0d growths, %0d refused allocates, %0d results checked",
             n_grants, n_growths, n_refused, results_seen);
    if (err_count == 0) begin
      $display("growable_object_pool_allocator_test: done, clean");
    end else begin
      $display("growable_object_pool_allocator_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/gpa_pkg.sv
rtl/core/gpa_ram.sv
rtl/core/gpa_cfg.sv
rtl/core/gpa_core.sv
rtl/core/growable_object_pool_allocator.sv
tb/growable_object_pool_allocator_test.sv
